// File: hw/rtl/majc_pkg.sv
package majc_pkg;

  localparam int MAX_IONS     = 1024;
  localparam int MAX_CLUSTERS = 64;

  localparam int ION_W   = $clog2(MAX_IONS);
  localparam int CL_W    = $clog2(MAX_CLUSTERS);
  localparam int CC_W    = $clog2(MAX_CLUSTERS + 1);
  localparam int TALLY_W = 11;
  localparam int ENTRY_W = CL_W + 1;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_VOTE = 1'b1;

  typedef struct packed {
    logic            action;
    logic [ION_W-1:0] ion;
    logic [CL_W-1:0]  member_cluster;
    logic            member_valid;
    logic            adjacent;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [ION_W-1:0] counterion_index;
    logic [CL_W-1:0]  assigned_cluster;
    logic            found;
  } out_item_t;

  // Membership entry: member flag above the cluster index.
  typedef struct packed {
    logic            member;
    logic [CL_W-1:0] cluster;
  } entry_t;

endpackage

// File: hw/rtl/majority_cluster_assign.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid / in_ready     | in_item (majc_pkg::in_item_t)
// out     | output    | out_valid / out_ready   | out_item (majc_pkg::out_item_t)
// cfg     | input     | cfg_we (no wait)        | cfg_wdata (cluster count)
//
// Items flow through a three-stage pipeline and one item is taken every cycle
// unless the pipeline holds or the clearing pass runs. The membership read is
// registered in the first stage, the tally read in the second, and the tally
// write plus best update happen in the third, which loads the result on out
// when it takes the vote that carries last. After reset the membership memory
// is cleared one entry a cycle; in_ready stays low until all 1024 entries are
// cleared. The whole pipeline holds while a result waits and out_ready is low.
module majority_cluster_assign (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  majc_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output majc_pkg::out_item_t   out_item,
  input  logic                  cfg_we,
  input  logic [majc_pkg::CC_W-1:0] cfg_wdata
);
  import majc_pkg::*;

  // Storage.
  entry_t                 member_mem [MAX_IONS];
  logic [TALLY_W-1:0]     tally_mem  [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] tally_vld_r;

  logic                   clr_busy_r;
  logic [ION_W-1:0]       clr_idx_r;
  logic [CC_W-1:0]        cluster_count_r;

  // Stage one: membership entry of the voted ion.
  logic                   s1_vote_r, s1_adj_r, s1_last_r;
  entry_t                 mem_rd_r;

  // Stage two: tally read and forwarding.
  logic                   s2_vote_r, s2_last_r, s2_cast_r;
  logic [CL_W-1:0]        s2_cl_r;
  logic [TALLY_W-1:0]     tally_rd_r;
  logic                   s2_tv_r, s2_fwd_r;
  logic [TALLY_W-1:0]     s2_fwd_val_r;

  logic [TALLY_W-1:0]     best_tally_r;
  logic [CL_W-1:0]        best_cl_r;
  logic [ION_W-1:0]       counter_r;

  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic                   adv, in_fire;
  logic                   mem_we;
  logic [ION_W-1:0]       mem_waddr;
  entry_t                 mem_wdata;
  logic                   s1_cast;
  logic                   s2_end;
  logic [TALLY_W-1:0]     s2_op, s2_tally_new;
  logic [TALLY_W-1:0]     best_tally_upd;
  logic [CL_W-1:0]        best_cl_upd;
  logic                   fwd_nxt;
  logic [TALLY_W-1:0]     fwd_val_nxt;

  // The pipeline moves whenever the output register is free or being drained.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !clr_busy_r;
  assign in_fire  = in_valid && in_ready;

  // Membership memory has a single write port shared by the clearing pass and loads.
  always_comb begin
    mem_we    = clr_busy_r || (in_fire && (in_item.action == ACTION_LOAD));
    mem_waddr = clr_busy_r ? clr_idx_r : in_item.ion;
    mem_wdata = '0;
    if (!clr_busy_r && in_item.member_valid) begin
      mem_wdata.member  = 1'b1;
      mem_wdata.cluster = in_item.member_cluster;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      member_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      mem_rd_r <= member_mem[in_item.ion];
    end
  end

  // A vote counts only for an adjacent member ion whose cluster is in use.
  assign s1_cast = s1_vote_r && s1_adj_r && mem_rd_r.member &&
                   (CC_W'(mem_rd_r.cluster) < cluster_count_r);

  assign s2_end = s2_vote_r && s2_last_r;

  // Tally operand: a write or run clear in the third stage at the same edge as
  // the read overrides the memory data; an entry not yet written this run is zero.
  assign s2_op        = s2_fwd_r ? s2_fwd_val_r : (s2_tv_r ? tally_rd_r : '0);
  assign s2_tally_new = (s2_op == TALLY_MAX) ? s2_op : s2_op + TALLY_W'(1);

  always_comb begin
    fwd_nxt     = 1'b0;
    fwd_val_nxt = s2_tally_new;
    if (s2_end) begin
      fwd_nxt     = 1'b1;
      fwd_val_nxt = '0;
    end else if (s2_cast_r && (s2_cl_r == mem_rd_r.cluster)) begin
      fwd_nxt = 1'b1;
    end
  end

  // Running best: higher tally wins, lower index wins a tie.
  always_comb begin
    best_tally_upd = best_tally_r;
    best_cl_upd    = best_cl_r;
    if (s2_cast_r) begin
      if (s2_tally_new > best_tally_r) begin
        best_tally_upd = s2_tally_new;
        best_cl_upd    = s2_cl_r;
      end else if ((s2_tally_new == best_tally_r) && (s2_cl_r < best_cl_r)) begin
        best_cl_upd = s2_cl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tally_rd_r   <= tally_mem[mem_rd_r.cluster];
      s2_cl_r      <= mem_rd_r.cluster;
      s2_tv_r      <= tally_vld_r[mem_rd_r.cluster];
      s2_fwd_val_r <= fwd_val_nxt;
      if (s2_cast_r) begin
        tally_mem[s2_cl_r] <= s2_tally_new;
      end
      if (s2_end) begin
        out_item_r.counterion_index <= counter_r;
        out_item_r.found            <= (best_tally_upd != '0);
        out_item_r.assigned_cluster <= (best_tally_upd != '0) ? best_cl_upd : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r      <= 1'b1;
      clr_idx_r       <= '0;
      cluster_count_r <= CC_W'(MAX_CLUSTERS);
      s1_vote_r       <= 1'b0;
      s1_adj_r        <= 1'b0;
      s1_last_r       <= 1'b0;
      s2_vote_r       <= 1'b0;
      s2_last_r       <= 1'b0;
      s2_cast_r       <= 1'b0;
      s2_fwd_r        <= 1'b0;
      tally_vld_r     <= '0;
      best_tally_r    <= '0;
      best_cl_r       <= '0;
      counter_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        cluster_count_r <= cfg_wdata;
      end
      if (clr_busy_r) begin
        clr_idx_r <= ION_W'(clr_idx_r + ION_W'(1));
        if (clr_idx_r == ION_W'(MAX_IONS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (adv) begin
        s1_vote_r   <= in_fire && (in_item.action == ACTION_VOTE);
        s1_adj_r    <= in_item.adjacent;
        s1_last_r   <= in_item.last;
        s2_vote_r   <= s1_vote_r;
        s2_last_r   <= s1_last_r;
        s2_cast_r   <= s1_cast;
        s2_fwd_r    <= fwd_nxt;
        out_valid_r <= s2_end;
        if (s2_end) begin
          // The finished run's tallies and best are dropped in one step.
          tally_vld_r  <= '0;
          best_tally_r <= '0;
          best_cl_r    <= '0;
          counter_r    <= ION_W'(counter_r + ION_W'(1));
        end else if (s2_cast_r) begin
          tally_vld_r[s2_cl_r] <= 1'b1;
          best_tally_r         <= best_tally_upd;
          best_cl_r            <= best_cl_upd;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A finished run leaves no best tally behind.
  a_run_clears_best: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_end) |=> (best_tally_r == '0) && (tally_vld_r == '0))
    else $error("best tally or tally valid bits survived the end of a run");

  // A result without a winner reports cluster zero.
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.found) |-> (out_item_r.assigned_cluster == '0))
    else $error("result without a winner carries a nonzero cluster");

  // The sequence number steps by one for every result produced.
  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_end) |=> (counter_r == ION_W'($past(counter_r) + ION_W'(1))))
    else $error("counterion sequence number did not advance by one");

  // No item is taken while the membership memory is being cleared.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_fire && !s1_vote_r)
    else $error("item taken during the membership clearing pass");

endmodule
